// ----- rtl/hcm_pkg.sv -----
package hcm_pkg;

   localparam int MAX_ORDER       = 4;
   localparam int LETTER_W        = 5;
   localparam int ROW_W           = 20;
   localparam int BLK_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CSR_DECRYPT_MODE  = 3'd0,
      CSR_PAD_LETTER    = 3'd1,
      CSR_KEY_ORDER     = 3'd2,
      CSR_KEY_ROW_ZERO  = 3'd3,
      CSR_KEY_ROW_ONE   = 3'd4,
      CSR_KEY_ROW_TWO   = 3'd5,
      CSR_KEY_ROW_THREE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      B_IDLE, B_CHECK, B_MUL, B_ACC, B_SCALE, B_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      I_IDLE, I_MUL1, I_MUL2, I_STORE, I_DET, I_FINISH
   } inv_state_type;

   typedef struct packed {
      logic [4:0] letter_in;
      logic       final_in;
   } req_item_type;

   typedef struct packed {
      logic [4:0] letter_out;
      logic       final_out;
      logic       key_error;
   } rsp_item_type;

   // one padded row vector on its way from front to back
   typedef struct packed {
      logic [3:0][4:0] letters;
      logic            fin;
   } blk_type;

   typedef struct packed {
      logic                  decrypt;
      logic [4:0]            pad;       // already reduced mod 26
      logic [2:0]            order;     // effective order, 1..MAX_ORDER
      logic [3:0][ROW_W-1:0] key_rows;
   } cfg_type;

   typedef struct packed {
      logic       busy;
      logic       ready;
      logic       invertible;
      logic [4:0] dinv;
   } inv_status_type;

   // x mod 26 for x < 1024: reciprocal estimate, then one correction
   function automatic logic [4:0] mod26(input logic [9:0] x);
      logic [18:0] scaled;
      logic [5:0]  q;
      logic [9:0]  r;
      scaled = {9'd0, x} * 19'd315;
      q = scaled[18:13];
      r = x - ({4'd0, q} * 10'd26);
      if (r >= 10'd26) r = r - 10'd26;
      return r[4:0];
   endfunction

   function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 6'd26) s = s - 6'd26;
      return s[4:0];
   endfunction

   function automatic logic [4:0] sub_mod(input logic [4:0] a, input logic [4:0] b);
      logic [5:0] s;
      s = {1'b0, a} + 6'd26 - {1'b0, b};
      if (s >= 6'd26) s = s - 6'd26;
      return s[4:0];
   endfunction

   function automatic logic [4:0] key_entry(input logic [3:0][ROW_W-1:0] rows,
                                            input logic [1:0] r, input logic [1:0] c);
      logic [ROW_W-1:0] row;
      logic [4:0]       raw;
      row = rows[r];
      raw = row[int'(c) * 5 +: 5];
      if (raw >= 5'd26) raw = raw - 5'd26;
      return raw;
   endfunction

   // inverse mod 26, zero when none exists
   function automatic logic [4:0] dinv_lookup(input logic [4:0] d);
      logic [4:0] v;
      case (d)
         5'd1:    v = 5'd1;
         5'd3:    v = 5'd9;
         5'd5:    v = 5'd21;
         5'd7:    v = 5'd15;
         5'd9:    v = 5'd3;
         5'd11:   v = 5'd19;
         5'd15:   v = 5'd7;
         5'd17:   v = 5'd23;
         5'd19:   v = 5'd11;
         5'd21:   v = 5'd5;
         5'd23:   v = 5'd17;
         5'd25:   v = 5'd25;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/hill_cipher_mod26_block_top.sv -----
// Channel  Ports                              Handshake
// req      req_push, req_full, req_item       taken when push & !full
// rsp      rsp_pop, rsp_empty, rsp_item       taken when pop & !empty
// csr      csr_we, csr_index, csr_wdata       write when we, no wait
//
// The back end forms each output letter from products of input letters and key
// entries, each multiplied and reduced mod 26 in turn and summed. The first
// decrypt block after a configuration write or reset adds an inverse build (six
// signed permutation terms per cofactor).
// Reset is synchronous; it empties both queues and clears the inverse.
// req_full follows the block queue; rsp_empty follows the result queue.
module hill_cipher_mod26_block_top #(
   parameter int BLK_DEPTH = hcm_pkg::BLK_QUEUE_DEPTH,
   parameter int RSP_DEPTH = hcm_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  hcm_pkg::req_item_type   req_item,
   output logic                    req_full,
   input  logic                    rsp_pop,
   output hcm_pkg::rsp_item_type   rsp_item,
   output logic                    rsp_empty,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [hcm_pkg::ROW_W-1:0] csr_wdata
);

   localparam int BLK_W = $bits(hcm_pkg::blk_type);
   localparam int RSP_W = $bits(hcm_pkg::rsp_item_type);

   logic                        decrypt_mode_ff;
   logic [4:0]                  pad_letter_ff;
   logic [2:0]                  key_order_ff;
   logic [3:0][hcm_pkg::ROW_W-1:0] key_rows_ff;
   logic                        cfg_clear;
   hcm_pkg::cfg_type            cfg;

   hcm_pkg::blk_type            front_blk, back_blk;
   logic                        blk_push, blk_full, blk_pop, blk_empty;
   hcm_pkg::inv_status_type     inv_status;
   logic                        inv_start;
   logic [3:0]                  adj_addr;
   logic [4:0]                  adj_data;
   hcm_pkg::rsp_item_type       back_rsp;
   logic                        rsp_push, rsp_full;

   always_comb begin
      cfg_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            hcm_pkg::CSR_DECRYPT_MODE, hcm_pkg::CSR_PAD_LETTER, hcm_pkg::CSR_KEY_ORDER,
            hcm_pkg::CSR_KEY_ROW_ZERO, hcm_pkg::CSR_KEY_ROW_ONE, hcm_pkg::CSR_KEY_ROW_TWO,
            hcm_pkg::CSR_KEY_ROW_THREE: cfg_clear = 1'b1;
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         pad_letter_ff   <= 5'd25;
         key_order_ff    <= 3'd3;
         key_rows_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            hcm_pkg::CSR_DECRYPT_MODE:  decrypt_mode_ff <= csr_wdata[0];
            hcm_pkg::CSR_PAD_LETTER:    pad_letter_ff   <= csr_wdata[4:0];
            hcm_pkg::CSR_KEY_ORDER:     key_order_ff    <= csr_wdata[2:0];
            hcm_pkg::CSR_KEY_ROW_ZERO:  key_rows_ff[0]  <= csr_wdata;
            hcm_pkg::CSR_KEY_ROW_ONE:   key_rows_ff[1]  <= csr_wdata;
            hcm_pkg::CSR_KEY_ROW_TWO:   key_rows_ff[2]  <= csr_wdata;
            hcm_pkg::CSR_KEY_ROW_THREE: key_rows_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.decrypt  = decrypt_mode_ff;
      cfg.pad      = (pad_letter_ff >= 5'd26) ? pad_letter_ff - 5'd26 : pad_letter_ff;
      cfg.key_rows = key_rows_ff;
      if (key_order_ff == 3'd0) begin
         cfg.order = 3'd1;
      end else if (key_order_ff > 3'(hcm_pkg::MAX_ORDER)) begin
         cfg.order = 3'(hcm_pkg::MAX_ORDER);
      end else begin
         cfg.order = key_order_ff;
      end
   end

   hcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .blk_full (blk_full),
      .blk_push (blk_push),
      .blk_data (front_blk)
   );

   hcm_fifo #(.WIDTH(BLK_W), .DEPTH(BLK_DEPTH)) u_blk_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (blk_push),
      .push_data (front_blk),
      .full      (blk_full),
      .pop       (blk_pop),
      .pop_data  (back_blk),
      .empty     (blk_empty)
   );

   hcm_inverse u_inverse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .start     (inv_start),
      .adj_addr  (adj_addr),
      .adj_data  (adj_data),
      .status    (inv_status)
   );

   hcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .blk_empty  (blk_empty),
      .blk_pop    (blk_pop),
      .blk_data   (back_blk),
      .inv_status (inv_status),
      .inv_start  (inv_start),
      .adj_addr   (adj_addr),
      .adj_data   (adj_data),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (back_rsp)
   );

   hcm_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule

// ----- rtl/hcm_fifo.sv -----
module hcm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/hcm_front.sv -----
module hcm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  hcm_pkg::cfg_type      cfg,
   input  logic                  req_push,
   input  hcm_pkg::req_item_type req_item,
   output logic                  req_full,
   input  logic                  blk_full,
   output logic                  blk_push,
   output hcm_pkg::blk_type      blk_data
);

   logic [3:0][4:0] buf_ff;
   logic [1:0]      fill_ff, fill_in;
   logic [4:0]      letter;
   logic [2:0]      used;
   logic            accept, complete;

   assign req_full = blk_full;
   assign accept   = req_push & ~blk_full;
   assign letter   = (req_item.letter_in >= 5'd26) ? req_item.letter_in - 5'd26
                                                   : req_item.letter_in;
   assign used     = {1'b0, fill_ff} + 3'd1;
   // a lowered order may already be met by what is buffered
   assign complete = (used >= cfg.order) | req_item.final_in;
   assign blk_push = accept & complete;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < used) begin
            blk_data.letters[k] = (2'(k) == fill_ff) ? letter : buf_ff[k];
         end else begin
            blk_data.letters[k] = cfg.pad;
         end
      end
      blk_data.fin = req_item.final_in;
      fill_in = fill_ff;
      if (accept) begin
         fill_in = complete ? 2'd0 : used[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[fill_ff] <= letter;
      end
   end

endmodule

// ----- rtl/hcm_inverse.sv -----
module hcm_inverse (
   input  logic                    clock,
   input  logic                    reset,
   input  hcm_pkg::cfg_type        cfg,
   input  logic                    cfg_clear,
   input  logic                    start,
   input  logic [3:0]              adj_addr,
   output logic [4:0]              adj_data,
   output hcm_pkg::inv_status_type status
);

   hcm_pkg::inv_state_type state_ff, state_in;
   logic [1:0] i_ff, i_in, j_ff, j_in;
   logic [2:0] p_ff, p_in;
   logic [4:0] acc_ff, acc_in, prod_ff, prod_in, det_ff, det_in, dinv_ff, dinv_in;
   logic       ready_ff, ready_in, invertible_ff, invertible_in;
   logic [4:0] adj_ff [16];
   logic       adj_we, step;
   logic [1:0] last;
   logic [6:0] pm;
   logic [4:0] term;

   // permutations of three with sign: {odd, s0, s1, s2}
   function automatic logic [6:0] perm(input logic [2:0] p);
      logic [6:0] v;
      case (p)
         3'd0:    v = {1'b0, 2'd0, 2'd1, 2'd2};
         3'd1:    v = {1'b1, 2'd0, 2'd2, 2'd1};
         3'd2:    v = {1'b1, 2'd1, 2'd0, 2'd2};
         3'd3:    v = {1'b0, 2'd1, 2'd2, 2'd0};
         3'd4:    v = {1'b0, 2'd2, 2'd0, 2'd1};
         default: v = {1'b1, 2'd2, 2'd1, 2'd0};
      endcase
      return v;
   endfunction

   // minor that drops row j, column i, padded to 3x3 with identity
   function automatic logic [4:0] elem(input logic [1:0] a, input logic [1:0] b,
                                       input logic [1:0] i, input logic [1:0] j,
                                       input hcm_pkg::cfg_type c);
      logic [2:0] m;
      logic [1:0] r, col;
      m   = c.order - 3'd1;
      r   = (a < j) ? a : 2'(a + 2'd1);
      col = (b < i) ? b : 2'(b + 2'd1);
      if (({1'b0, a} < m) && ({1'b0, b} < m)) begin
         return hcm_pkg::key_entry(c.key_rows, r, col);
      end
      return (a == b) ? 5'd1 : 5'd0;
   endfunction

   assign last     = 2'(cfg.order - 3'd1);
   assign pm       = perm(p_ff);
   assign adj_data = adj_ff[adj_addr];

   assign status.busy       = (state_ff != hcm_pkg::I_IDLE);
   assign status.ready      = ready_ff;
   assign status.invertible = invertible_ff;
   assign status.dinv       = dinv_ff;

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      det_in        = det_ff;
      dinv_in       = dinv_ff;
      ready_in      = ready_ff;
      invertible_in = invertible_ff;
      adj_we        = 1'b0;
      step          = 1'b0;
      term          = hcm_pkg::mod26({5'd0, prod_ff} *
                                     {5'd0, elem(2'd2, pm[1:0], i_ff, j_ff, cfg)});
      unique case (state_ff)
         hcm_pkg::I_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = '0;
               p_in     = '0;
               acc_in   = '0;
               det_in   = '0;
               state_in = hcm_pkg::I_MUL1;
            end
         end
         hcm_pkg::I_MUL1: begin
            prod_in  = hcm_pkg::mod26({5'd0, elem(2'd0, pm[5:4], i_ff, j_ff, cfg)} *
                                      {5'd0, elem(2'd1, pm[3:2], i_ff, j_ff, cfg)});
            state_in = hcm_pkg::I_MUL2;
         end
         hcm_pkg::I_MUL2: begin
            // cofactor sign folded into the permutation sign
            if (pm[6] ^ i_ff[0] ^ j_ff[0]) begin
               acc_in = hcm_pkg::sub_mod(acc_ff, term);
            end else begin
               acc_in = hcm_pkg::add_mod(acc_ff, term);
            end
            if (p_ff == 3'd5) begin
               state_in = hcm_pkg::I_STORE;
            end else begin
               p_in     = p_ff + 3'd1;
               state_in = hcm_pkg::I_MUL1;
            end
         end
         hcm_pkg::I_STORE: begin
            adj_we = 1'b1;
            if (j_ff == 2'd0) begin
               state_in = hcm_pkg::I_DET;
            end else begin
               step = 1'b1;
            end
         end
         hcm_pkg::I_DET: begin
            // det = sum over i of key[0][i] * adj[i][0]
            det_in = hcm_pkg::add_mod(det_ff, hcm_pkg::mod26(
                        {5'd0, hcm_pkg::key_entry(cfg.key_rows, 2'd0, i_ff)} *
                        {5'd0, acc_ff}));
            step   = 1'b1;
         end
         hcm_pkg::I_FINISH: begin
            dinv_in       = hcm_pkg::dinv_lookup(det_ff);
            invertible_in = (hcm_pkg::dinv_lookup(det_ff) != 5'd0);
            ready_in      = 1'b1;
            state_in      = hcm_pkg::I_IDLE;
         end
         default: state_in = hcm_pkg::I_IDLE;
      endcase
      if (step) begin
         acc_in   = '0;
         p_in     = '0;
         state_in = hcm_pkg::I_MUL1;
         if (j_ff == last) begin
            j_in = '0;
            if (i_ff == last) begin
               state_in = hcm_pkg::I_FINISH;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end else begin
            j_in = j_ff + 2'd1;
         end
      end
      if (cfg_clear) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hcm_pkg::I_IDLE;
         ready_ff      <= 1'b0;
         invertible_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ready_ff      <= ready_in;
         invertible_ff <= invertible_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      det_ff  <= det_in;
      dinv_ff <= dinv_in;
      if (adj_we) begin
         adj_ff[{i_ff, j_ff}] <= acc_ff;
      end
   end

endmodule

// ----- rtl/hcm_back.sv -----
module hcm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  hcm_pkg::cfg_type        cfg,
   input  logic                    blk_empty,
   output logic                    blk_pop,
   input  hcm_pkg::blk_type        blk_data,
   input  hcm_pkg::inv_status_type inv_status,
   output logic                    inv_start,
   output logic [3:0]              adj_addr,
   input  logic [4:0]              adj_data,
   input  logic                    rsp_full,
   output logic                    rsp_push,
   output hcm_pkg::rsp_item_type   rsp_data
);

   hcm_pkg::back_state_type state_ff, state_in;
   hcm_pkg::blk_type vec_ff, vec_in;
   logic [1:0] j_ff, j_in, k_ff, k_in, last;
   logic [4:0] acc_ff, acc_in, prod_ff, prod_in, m_sel;
   logic       err_ff, err_in;

   assign last     = 2'(cfg.order - 3'd1);
   assign adj_addr = {k_ff, j_ff};
   assign m_sel    = cfg.decrypt ? adj_data : hcm_pkg::key_entry(cfg.key_rows, k_ff, j_ff);

   always_comb begin
      state_in  = state_ff;
      vec_in    = vec_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      err_in    = err_ff;
      blk_pop   = 1'b0;
      inv_start = 1'b0;
      rsp_push  = 1'b0;
      rsp_data.letter_out = err_ff ? 5'd0 : acc_ff;
      rsp_data.final_out  = vec_ff.fin & (j_ff == last);
      rsp_data.key_error  = err_ff;
      unique case (state_ff)
         hcm_pkg::B_IDLE: begin
            if (!blk_empty) begin
               blk_pop  = 1'b1;
               vec_in   = blk_data;
               state_in = hcm_pkg::B_CHECK;
            end
         end
         hcm_pkg::B_CHECK: begin
            if (cfg.decrypt && !inv_status.ready) begin
               inv_start = ~inv_status.busy;
            end else begin
               err_in   = cfg.decrypt & ~inv_status.invertible;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = (cfg.decrypt && !inv_status.invertible) ? hcm_pkg::B_EMIT
                                                                 : hcm_pkg::B_MUL;
            end
         end
         hcm_pkg::B_MUL: begin
            prod_in  = hcm_pkg::mod26({5'd0, vec_ff.letters[k_ff]} * {5'd0, m_sel});
            state_in = hcm_pkg::B_ACC;
         end
         hcm_pkg::B_ACC: begin
            acc_in = hcm_pkg::add_mod(acc_ff, prod_ff);
            if (k_ff == last) begin
               state_in = hcm_pkg::B_SCALE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = hcm_pkg::B_MUL;
            end
         end
         hcm_pkg::B_SCALE: begin
            // decrypt keeps the adjugate; scale by det inverse here
            if (cfg.decrypt) begin
               acc_in = hcm_pkg::mod26({5'd0, acc_ff} * {5'd0, inv_status.dinv});
            end
            state_in = hcm_pkg::B_EMIT;
         end
         hcm_pkg::B_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (j_ff == last) begin
                  state_in = hcm_pkg::B_IDLE;
               end else begin
                  j_in     = j_ff + 2'd1;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = err_ff ? hcm_pkg::B_EMIT : hcm_pkg::B_MUL;
               end
            end
         end
         default: state_in = hcm_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcm_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      err_ff  <= err_in;
   end

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      inv_start |=> inv_status.busy)
      else $error("inverse build did not start");

   a_mul_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hcm_pkg::B_MUL) |=> (state_ff == hcm_pkg::B_ACC))
      else $error("product not accumulated");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.key_error) |-> (rsp_data.letter_out == 5'd0))
      else $error("error item carries a letter");

   a_err_decrypt: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.key_error) |-> (cfg.decrypt && inv_status.ready))
      else $error("error item without decrypt inverse");

endmodule

// ----- verif/tb_hill_cipher_mod26_block_top.sv -----
module tb_hill_cipher_mod26_block_top;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES = 300;

   typedef int mat_type[4][4];

   typedef enum logic [1:0] {ROW_CSR, ROW_ITEM, ROW_DRAIN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   idx;
      int           data;
      int           letter;
      bit           fin;
      bit           typed;
      int           exp_letter;
      bit           exp_err;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   hcm_pkg::req_item_type req_item = '0;
   logic req_full;
   logic rsp_pop = 0;
   hcm_pkg::rsp_item_type rsp_item;
   logic rsp_empty;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [hcm_pkg::ROW_W-1:0] csr_wdata = '0;

   hill_cipher_mod26_block_top i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_item(req_item), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_item(rsp_item), .rsp_empty(rsp_empty),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow configuration and letter buffer
   int mdl_decrypt, mdl_pad, mdl_order;
   int mdl_rows[4];
   int mdl_buf[4];
   int mdl_fill;

   hcm_pkg::rsp_item_type cipher_q[$];
   int errors = 0;
   int cycles = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit hold_req = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("hill_cipher_mod26_block_top: mismatch");
         $finish;
      end
   end

   function automatic int order_eff();
      int n;
      n = mdl_order & 7;
      if (n < 1) n = 1;
      if (n > hcm_pkg::MAX_ORDER) n = hcm_pkg::MAX_ORDER;
      return n;
   endfunction

   function automatic int key_at(int r, int c);
      return ((mdl_rows[r] >> (5 * c)) & 31) % 26;
   endfunction

   // permutation expansion, n up to 4
   function automatic int det_mod26(mat_type m, int n);
      int acc, prod, inv_cnt, a, b, c, d, i, j;
      int p[4];
      bit ok;
      acc = 0;
      for (a = 0; a < n; a++)
         for (b = 0; b < ((n > 1) ? n : 1); b++)
            for (c = 0; c < ((n > 2) ? n : 1); c++)
               for (d = 0; d < ((n > 3) ? n : 1); d++) begin
                  p[0] = a; p[1] = b; p[2] = c; p[3] = d;
                  ok = 1;
                  inv_cnt = 0;
                  for (i = 0; i < n; i++)
                     for (j = i + 1; j < n; j++) begin
                        if (p[i] == p[j]) ok = 0;
                        if (p[i] > p[j]) inv_cnt++;
                     end
                  if (ok) begin
                     prod = 1;
                     for (i = 0; i < n; i++) prod = (prod * m[i][p[i]]) % 26;
                     if (inv_cnt & 1) acc = (acc + 26 - prod) % 26;
                     else acc = (acc + prod) % 26;
                  end
               end
      return acc;
   endfunction

   function automatic bit build_inv_key(output int inv[16]);
      mat_type key, sub;
      int n, d, dinv, x, i, j, r, c, ri, ci, cof;
      n = order_eff();
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++) begin
            key[r][c] = (r < n && c < n) ? key_at(r, c) : 0;
            sub[r][c] = 0;
         end
      for (i = 0; i < 16; i++) inv[i] = 0;
      d = det_mod26(key, n);
      dinv = 0;
      for (x = 25; x >= 1; x--) if ((d * x) % 26 == 1) dinv = x;
      if (dinv == 0) return 0;
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) begin
            if (n == 1) begin
               cof = 1;
            end else begin
               ri = 0;
               for (r = 0; r < n; r++) if (r != j) begin
                  ci = 0;
                  for (c = 0; c < n; c++) if (c != i) begin
                     sub[ri][ci] = key[r][c];
                     ci++;
                  end
                  ri++;
               end
               cof = det_mod26(sub, n - 1);
               if ((i + j) & 1) cof = (26 - cof) % 26;
            end
            inv[i * 4 + j] = (cof * dinv) % 26;
         end
      return 1;
   endfunction

   // returns number of cipher letters produced
   function automatic int cipher_step(hcm_pkg::req_item_type it);
      int n, used, j, k, acc, mval;
      int vec[4];
      int inv[16];
      bit err;
      hcm_pkg::rsp_item_type r;
      n = order_eff();
      mdl_buf[mdl_fill & 3] = it.letter_in % 26;
      used = (mdl_fill & 3) + 1;
      if (used < n && !it.final_in) begin
         mdl_fill = used;
         return 0;
      end
      mdl_fill = 0;
      for (k = 0; k < 4; k++) vec[k] = (k < used) ? mdl_buf[k] : mdl_pad % 26;
      err = 0;
      if (mdl_decrypt) err = !build_inv_key(inv);
      for (j = 0; j < n; j++) begin
         acc = 0;
         if (!err)
            for (k = 0; k < n; k++) begin
               mval = mdl_decrypt ? inv[k * 4 + j] : key_at(k, j);
               acc = (acc + vec[k] * mval) % 26;
            end
         r.letter_out = acc[4:0];
         r.final_out = it.final_in && (j + 1 == n);
         r.key_error = err;
         cipher_q.push_back(r);
      end
      return n;
   endfunction

   task automatic wait_drain();
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int val);
      @(negedge clock);
      req_push <= 0;
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val[hcm_pkg::ROW_W-1:0];
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         hcm_pkg::CSR_DECRYPT_MODE:  mdl_decrypt = val & 1;
         hcm_pkg::CSR_PAD_LETTER:    mdl_pad = val & 31;
         hcm_pkg::CSR_KEY_ORDER:     mdl_order = val & 7;
         hcm_pkg::CSR_KEY_ROW_ZERO:  mdl_rows[0] = val & 20'hFFFFF;
         hcm_pkg::CSR_KEY_ROW_ONE:   mdl_rows[1] = val & 20'hFFFFF;
         hcm_pkg::CSR_KEY_ROW_TWO:   mdl_rows[2] = val & 20'hFFFFF;
         hcm_pkg::CSR_KEY_ROW_THREE: mdl_rows[3] = val & 20'hFFFFF;
         default: ;
      endcase
   endtask

   // push stays high across back-to-back items; lowered on idle cycles, by stop_push and by CSR writes
   task automatic send_letter(int letter, bit fin, output int nres);
      hcm_pkg::req_item_type it;
      it.letter_in = letter[4:0];
      it.final_in = fin;
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      nres = cipher_step(it);
   endtask

   task automatic stop_push();
      @(negedge clock);
      req_push <= 0;
   endtask

   // receiver
   int hold_left = 0;
   initial begin
      hcm_pkg::rsp_item_type e;
      forever begin
         @(negedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (cipher_q.size() == 0) begin
               $display("%0t unexpected item: expected none actual %p", $time, rsp_item);
               errors++;
            end else begin
               e = cipher_q.pop_front();
               if (rsp_item.letter_out !== e.letter_out || rsp_item.final_out !== e.final_out
                   || rsp_item.key_error !== e.key_error) begin
                  $display("%0t item mismatch: expected %p actual %p", $time, e, rsp_item);
                  errors++;
               end
            end
         end
      end
   end

   stim_row_type dir_rows[$];

   function automatic void add_csr(logic [2:0] idx, int val);
      stim_row_type r;
      r = '{ROW_CSR, idx, val, 0, 0, 0, 0, 0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_item(int letter, bit fin);
      stim_row_type r;
      r = '{ROW_ITEM, 0, 0, letter, fin, 0, 0, 0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_typed(int letter, bit fin, int exp_letter, bit exp_err);
      stim_row_type r;
      r = '{ROW_ITEM, 0, 0, letter, fin, 1, exp_letter, exp_err};
      dir_rows.push_back(r);
   endfunction

   initial begin
      int nres, k, ph, it_cnt;
      mdl_decrypt = 0; mdl_pad = 25; mdl_order = 3;
      for (k = 0; k < 4; k++) begin
         mdl_rows[k] = 0;
         mdl_buf[k] = 0;
      end
      mdl_fill = 0;

      // zero key after reset: everything encrypts to a
      add_item(0, 0); add_item(25, 0); add_typed(31, 1, 0, 0);
      // zero key cannot be inverted
      add_csr(hcm_pkg::CSR_DECRYPT_MODE, 1);
      add_typed(5, 1, 0, 1);
      // order one, inverse of the single entry
      add_csr(hcm_pkg::CSR_KEY_ORDER, 1); add_csr(hcm_pkg::CSR_KEY_ROW_ZERO, 3);
      add_item(25, 0); add_item(1, 1);
      add_csr(hcm_pkg::CSR_DECRYPT_MODE, 0);
      add_item(7, 0);
      add_csr(hcm_pkg::CSR_KEY_ORDER, 0);
      add_item(30, 0);
      // order above max, entries above 25
      add_csr(hcm_pkg::CSR_KEY_ORDER, 7);
      add_csr(hcm_pkg::CSR_KEY_ROW_ZERO, 20'hFFFFF);
      add_csr(hcm_pkg::CSR_KEY_ROW_ONE, 20'h12345);
      add_csr(hcm_pkg::CSR_KEY_ROW_TWO, 20'hABCDE);
      add_csr(hcm_pkg::CSR_KEY_ROW_THREE, 20'h5A5A5);
      add_item(0, 0); add_item(25, 0); add_item(13, 0); add_item(31, 0);
      // partial final vector, pad above 25
      add_csr(hcm_pkg::CSR_PAD_LETTER, 31);
      add_item(2, 1);
      // order lowered while three letters wait
      add_item(4, 0); add_item(9, 0); add_item(17, 0);
      add_csr(hcm_pkg::CSR_KEY_ORDER, 2);
      add_item(11, 0);
      add_csr(3'd7, 20'hFFFFF);
      // invertible 2x2 key: rows (3,3) and (2,5)
      add_csr(hcm_pkg::CSR_KEY_ROW_ZERO, 3 | (3 << 5));
      add_csr(hcm_pkg::CSR_KEY_ROW_ONE, 2 | (5 << 5));
      add_csr(hcm_pkg::CSR_DECRYPT_MODE, 1);
      add_item(7, 0); add_item(8, 0); add_item(0, 1);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            stop_push();
            wait_drain();
            csr_write(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_letter(dir_rows[i].letter, dir_rows[i].fin, nres);
            if (dir_rows[i].typed)
               for (k = cipher_q.size() - nres; k < cipher_q.size(); k++) begin
                  cipher_q[k].letter_out = dir_rows[i].exp_letter[4:0];
                  cipher_q[k].key_error = dir_rows[i].exp_err;
               end
         end
      end

      for (ph = 0; ph < 3; ph++) begin
         snd_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 48 : 0;
         rcv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 8 : 0;
         for (int s = 0; s < 3; s++) begin
            stop_push();
            wait_drain();
            csr_write(hcm_pkg::CSR_DECRYPT_MODE, $urandom_range(0, 1));
            csr_write(hcm_pkg::CSR_PAD_LETTER, $urandom_range(0, 31));
            csr_write(hcm_pkg::CSR_KEY_ORDER, ($urandom_range(0, 9) == 0)
                                              ? $urandom_range(0, 7) : $urandom_range(1, 4));
            csr_write(hcm_pkg::CSR_KEY_ROW_ZERO, $urandom_range(0, 20'hFFFFF));
            csr_write(hcm_pkg::CSR_KEY_ROW_ONE, $urandom_range(0, 20'hFFFFF));
            csr_write(hcm_pkg::CSR_KEY_ROW_TWO, $urandom_range(0, 20'hFFFFF));
            csr_write(hcm_pkg::CSR_KEY_ROW_THREE, $urandom_range(0, 20'hFFFFF));
            if (ph == 2 && s == 0) hold_req = 1;
            for (it_cnt = 0; it_cnt < 19; it_cnt++)
               send_letter($urandom_range(0, 31), $urandom_range(0, 7) == 0, nres);
            send_letter($urandom_range(0, 31), 1, nres);
         end
      end

      stop_push();
      wait_drain();
      if (errors == 0) begin
         $display("hill_cipher_mod26_block_top: match");
      end else begin
         $display("hill_cipher_mod26_block_top: mismatch");
      end
      $finish;
   end

endmodule
